// ===== rtl/tlprq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlprq_pkg
// shared types, sizes and codes of the two-level priority run queue
// ----------------------------------------------------------------------------
package tlprq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ID_BITS     = 16;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int TASK_W    = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // queue select: 1 is the high priority queue
  typedef struct packed {
    logic                 we;
    logic                 wq;
    logic [IDX_W-1:0]     widx;
    logic [ID_BITS-1:0]   wdata;
    logic                 rq;
    logic [IDX_W-1:0]     ridx;
  } mem_req_t;

  // slot of a ring buffer: base plus offset, folded once into the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = (IDX_W+1)'(base) + (IDX_W+1)'(off);
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/tlprq_mem.sv =====
// ----------------------------------------------------------------------------
// tlprq_mem
// entry store of both queues, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tlprq_mem (
  input  logic                       clk,
  input  tlprq_pkg::mem_req_t        req,
  output logic [tlprq_pkg::ID_BITS-1:0] rd_data
);
  import tlprq_pkg::*;

  logic [ID_BITS-1:0] mem_r [2][QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.wq][req.widx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[req.rq][req.ridx];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/two_level_priority_run_queue.sv =====
// ----------------------------------------------------------------------------
// two_level_priority_run_queue
// high and low priority task queues with enqueue, dequeue and remove by id
// ----------------------------------------------------------------------------
// Each queue is a ring buffer of QUEUE_DEPTH task ids in one shared entry
// store that takes one write and one registered read per cycle. The block
// handles one command at a time and drops in_tready until the result is
// formed. An enqueue writes its slot in S_EXEC unless the queue is full; a
// dequeue reads the head slot in S_EXEC and takes the data in S_POP. A
// remove walks the high queue and then the low one, reading and comparing
// one entry at a time; on a match each entry behind it moves up one slot.
// The store port, one entry read or moved per visit, sets the remove time.
// in_tready comes back the cycle after the result is loaded. The result
// waits in its own register, so the next command is taken while the last
// result is pending.
// The store is not cleared at reset; only entries below a queue's count are
// ever read back.
// ----------------------------------------------------------------------------
module two_level_priority_run_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlprq_pkg::IN_DATA_W-1:0]    in_tdata,   // task_id, is_high, to_front, zero fill
  input  logic [1:0]                         in_tuser,   // operation
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlprq_pkg::OUT_DATA_W-1:0]   out_tdata,  // out_task_id, from_high, zero fill
  output logic [1:0]                         out_tuser   // status
);
  import tlprq_pkg::*;

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_EXEC     = 9'b000000010,
    S_POP      = 9'b000000100,
    S_SRCH_RD  = 9'b000001000,
    S_SRCH_CMP = 9'b000010000,
    S_SH_RD    = 9'b000100000,
    S_SH_WR    = 9'b001000000,
    S_DONE     = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // captured command
  op_t                op_r;
  logic [ID_BITS-1:0] id_r;
  logic               is_high_r;
  logic               to_front_r;
  logic [31:0]        id_ext;

  // queue bookkeeping, index 1 is the high queue
  logic [IDX_W-1:0] head_r   [2];
  logic [IDX_W-1:0] head_nxt [2];
  logic [CNT_W-1:0] cnt_r    [2];
  logic [CNT_W-1:0] cnt_nxt  [2];

  // walk state of remove
  logic             q_r, q_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;

  // result being formed
  status_t           res_status_r, res_status_nxt;
  logic [TASK_W-1:0] res_id_r, res_id_nxt;
  logic              res_high_r, res_high_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [TASK_W-1:0] out_id_r;
  logic              out_high_r;
  logic              out_load;

  // shared slot adder and store port
  logic               cur_q;
  logic [CNT_W-1:0]   off;
  logic [IDX_W-1:0]   phys;
  logic [IDX_W-1:0]   head_dec;
  logic [IDX_W-1:0]   head_inc;
  logic               cur_full;
  mem_req_t           mem_req;
  logic [ID_BITS-1:0] rd_data;
  logic [31:0]        rd_ext;
  logic               in_xfer;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign id_ext = 32'(in_tdata[TASK_W-1:0]);
  assign rd_ext = 32'(rd_data);

  tlprq_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // command capture, payload only
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r       <= op_t'(in_tuser);
      id_r       <= id_ext[ID_BITS-1:0];
      is_high_r  <= in_tdata[TASK_W];
      to_front_r <= in_tdata[TASK_W+1];
    end
  end

  // queue picked by the command, walk queue otherwise
  always_comb begin
    cur_q = q_r;
    if (state_r == S_EXEC) begin
      case (op_r)
        OP_ENQUEUE: cur_q = is_high_r;
        OP_DEQUEUE: cur_q = (cnt_r[1] != '0);
        default:    cur_q = 1'b1;
      endcase
    end
  end

  // offset into the picked queue for the slot adder
  always_comb begin
    case (state_r)
      S_EXEC:    off = (op_r == OP_ENQUEUE) ? cnt_r[cur_q] : '0;
      S_SRCH_RD: off = i_r;
      S_SH_RD:   off = i_r + CNT_W'(1);
      S_SH_WR:   off = i_r;
      default:   off = '0;
    endcase
  end

  assign phys     = wrap_idx(head_r[cur_q], off);
  assign head_dec = (head_r[cur_q] == '0) ? IDX_W'(QUEUE_DEPTH - 1)
                                           : head_r[cur_q] - IDX_W'(1);
  assign head_inc = (head_r[cur_q] == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                           : head_r[cur_q] + IDX_W'(1);
  assign cur_full = (cnt_r[cur_q] == CNT_W'(QUEUE_DEPTH));

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    q_nxt          = q_r;
    i_nxt          = i_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_high_nxt   = res_high_r;

    mem_req.we    = 1'b0;
    mem_req.wq    = cur_q;
    mem_req.widx  = phys;
    mem_req.wdata = id_r;
    mem_req.rq    = cur_q;
    mem_req.ridx  = phys;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_high_nxt   = 1'b0;
          state_nxt      = S_EXEC;
        end
      end

      S_EXEC: begin
        q_nxt = cur_q;
        i_nxt = '0;
        case (op_r)
          OP_ENQUEUE: begin
            state_nxt = S_DONE;
            if (cur_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_req.we = 1'b1;
              if (to_front_r) begin
                mem_req.widx   = head_dec;
                head_nxt[cur_q] = head_dec;
              end
              cnt_nxt[cur_q] = cnt_r[cur_q] + CNT_W'(1);
            end
          end
          OP_DEQUEUE: begin
            if (cnt_r[cur_q] == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              // read issued at the head slot, data lands in S_POP
              head_nxt[cur_q] = head_inc;
              cnt_nxt[cur_q]  = cnt_r[cur_q] - CNT_W'(1);
              res_high_nxt    = cur_q;
              state_nxt       = S_POP;
            end
          end
          OP_REMOVE: state_nxt = S_SRCH_RD;
          default:   state_nxt = S_DONE;
        endcase
      end

      S_POP: begin
        res_id_nxt = rd_ext[TASK_W-1:0];
        state_nxt  = S_DONE;
      end

      S_SRCH_RD: begin
        if (i_r == cnt_r[q_r]) begin
          if (q_r) begin
            // high queue exhausted, go on with the low one
            q_nxt = 1'b0;
            i_nxt = '0;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (rd_data == id_r) begin
          res_high_nxt = q_r;
          state_nxt    = S_SH_RD;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end

      // close the gap: entry i+1 moves into slot i
      S_SH_RD: begin
        if (i_r + CNT_W'(1) == cnt_r[q_r]) begin
          cnt_nxt[q_r] = cnt_r[q_r] - CNT_W'(1);
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = rd_data;
        i_nxt         = i_r + CNT_W'(1);
        state_nxt     = S_SH_RD;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r[0]   <= '0;
      head_r[1]   <= '0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      q_r         <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      q_r         <= q_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_high_r   <= res_high_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_high_r   <= res_high_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_DATA_W - TASK_W - 1)'(0), out_high_r, out_id_r};

endmodule

// ===== rtl/tlprq_checker.sv =====
// ----------------------------------------------------------------------------
// tlprq_checker
// port-level checks of the two-level priority run queue
// ----------------------------------------------------------------------------
module tlprq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlprq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser
);
  import tlprq_pkg::*;

  // a held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the block is busy right after taking a command
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while previous one in progress");

  // failed commands return no task id
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_FULL ||
                   out_tuser == ST_NOT_FOUND) |-> out_tdata[TASK_W-1:0] == '0)
    else $error("task id on a failed command");

  // an empty result never claims the high queue
  a_empty_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> !out_tdata[TASK_W])
    else $error("empty result flagged as high queue");

endmodule

bind two_level_priority_run_queue tlprq_checker u_tlprq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
